### hw/rtl/aip_pkg.sv
`timescale 1ns / 1ps
package aip_pkg;

  localparam int CH_W     = 8;
  localparam int VALUE_W  = 64;
  localparam int OFFSET_W = 16;
  localparam int RADIX_W  = 5;
  localparam int DIGIT_W  = 6;
  localparam int MAC_D_W  = 4;

  localparam logic [RADIX_W-1:0] RADIX_AUTO = 5'd0;
  localparam logic [RADIX_W-1:0] RADIX_ONE  = 5'd1;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 5'd16;

  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;

  localparam logic [VALUE_W-1:0] MAG_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] MAG_NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGNED,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

endpackage

### hw/rtl/aip_in_if.sv
`timescale 1ns / 1ps
interface aip_in_if;
  import aip_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            start_req;

  modport source (output valid, output ch, output start_req, input ready);
  modport sink (input valid, input ch, input start_req, output ready);
endinterface

### hw/rtl/aip_out_if.sv
`timescale 1ns / 1ps
interface aip_out_if;
  import aip_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [OFFSET_W-1:0] end_offset;
  logic                overflowed;
  logic                converted;

  modport source (output valid, output value, output end_offset, output overflowed,
                  output converted, input ready);
  modport sink (input valid, input value, input end_offset, input overflowed,
                input converted, output ready);
endinterface

### hw/rtl/aip_mac.sv
`timescale 1ns / 1ps
module aip_mac (
  input  logic [aip_pkg::VALUE_W-1:0] acc,
  input  logic [aip_pkg::RADIX_W-1:0] radix,
  input  logic [aip_pkg::MAC_D_W-1:0] digit,
  input  logic                        negative,
  input  logic                        saturated,
  output logic [aip_pkg::VALUE_W-1:0] acc_nxt,
  output logic                        sat_nxt
);
  import aip_pkg::*;

  localparam int PROD_W = VALUE_W + RADIX_W;

  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] limit;
  logic               over;

  // acc*radix + d above the limit is the same test as acc > (limit - d) / radix
  always_comb begin
    prod    = PROD_W'(acc) * PROD_W'(radix) + PROD_W'(digit);
    limit   = negative ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
    over    = saturated || (prod > PROD_W'(limit));
    acc_nxt = over ? limit : prod[VALUE_W-1:0];
    sat_nxt = over;
  end
endmodule

### hw/rtl/ascii_integer_parser.sv
`timescale 1ns / 1ps
// channel   dir  handshake       payload
// in_s      in   valid/ready     ch, start_req
// out_s     out  valid/ready     value, end_offset, overflowed, converted
// cfg       in   cfg_we          cfg_wdata (radix_select)
//
// one character per cycle unless a result is stalled; a character is registered,
// then one pass of decode and saturating multiply-add updates the parse state
// each result is registered at out_s; the 64x5 multiply-add sets the cycle
// synchronous active-low reset clears the parse state and radix_select
// a character that ends the string waits in the input register only while
// an earlier result is still held in the output register and not yet taken
module ascii_integer_parser #(
  parameter int POSITION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  aip_in_if.sink                      in_s,
  aip_out_if.source                   out_s,
  input  logic                        cfg_we,
  input  logic [aip_pkg::RADIX_W-1:0] cfg_wdata
);
  import aip_pkg::*;

  localparam int PW = POSITION_BITS;

  // configuration
  logic [RADIX_W-1:0] radix_select_r;

  // input register
  logic            in_v_r;
  logic [CH_W-1:0] ch_r;
  logic            start_r;

  // parse state
  phase_t             phase_r, phase_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic               sat_r, sat_nxt;
  logic [PW-1:0]      pfo_r, pfo_nxt;

  // result register
  logic                out_v_r;
  logic [VALUE_W-1:0]  value_r;
  logic [OFFSET_W-1:0] end_r;
  logic                ovf_r;
  logic                conv_r;

  // effective state, start_req clears the parse
  phase_t             eff_phase;
  logic [VALUE_W-1:0] eff_acc;
  logic               eff_neg;
  logic [RADIX_W-1:0] eff_radix;
  logic [PW-1:0]      eff_pos;
  logic               eff_sat;
  logic [PW-1:0]      eff_pfo;
  logic [PW-1:0]      pos_inc;

  logic               dvalid;
  logic [DIGIT_W-1:0] dval;
  logic               is_ws, is_sign, is_x;
  logic [RADIX_W-1:0] sel_radix, first_radix, mac_radix;
  logic               zero_prefix, first_ok, hex_ok, mac_ok;
  logic [VALUE_W-1:0] mac_acc;
  logic               mac_sat;

  logic               emit;
  logic [VALUE_W-1:0] mag;
  logic [PW-1:0]      end_pos;
  logic               conv;
  logic [31:0]        end_ext;
  logic               out_free, fire;

  assign eff_phase = start_r ? PH_WS : phase_r;
  assign eff_acc   = start_r ? '0 : acc_r;
  assign eff_neg   = start_r ? 1'b0 : neg_r;
  assign eff_radix = start_r ? RADIX_AUTO : radix_r;
  assign eff_pos   = start_r ? '0 : pos_r;
  assign eff_sat   = start_r ? 1'b0 : sat_r;
  assign eff_pfo   = start_r ? '0 : pfo_r;
  assign pos_inc   = (&eff_pos) ? eff_pos : eff_pos + 1'b1;

  // character decode
  always_comb begin
    dvalid = 1'b1;
    dval   = '0;
    if (ch_r >= CH_0 && ch_r <= CH_9) begin
      dval = DIGIT_W'(ch_r - CH_0);
    end else if (ch_r >= CH_LA && ch_r <= CH_LZ) begin
      dval = DIGIT_W'(ch_r - CH_LA + 8'd10);
    end else if (ch_r >= CH_UA && ch_r <= CH_UZ) begin
      dval = DIGIT_W'(ch_r - CH_UA + 8'd10);
    end else begin
      dvalid = 1'b0;
    end
  end

  assign is_ws   = (ch_r == CH_SPACE) || (ch_r >= CH_TAB && ch_r <= CH_CR);
  assign is_sign = (ch_r == CH_PLUS) || (ch_r == CH_MINUS);
  assign is_x    = (ch_r == CH_LX) || (ch_r == CH_UX);

  // radix 1 behaves as auto, anything above sixteen as sixteen
  always_comb begin
    if (radix_select_r == RADIX_ONE) begin
      sel_radix = RADIX_AUTO;
    end else if (radix_select_r > RADIX_HEX) begin
      sel_radix = RADIX_HEX;
    end else begin
      sel_radix = radix_select_r;
    end
  end

  assign first_radix = (sel_radix == RADIX_AUTO) ? RADIX_DEC : sel_radix;
  assign zero_prefix = (ch_r == CH_0) && (sel_radix == RADIX_AUTO || sel_radix == RADIX_HEX);
  assign first_ok    = dvalid && (dval < DIGIT_W'(first_radix));
  assign hex_ok      = dvalid && (dval < DIGIT_W'(RADIX_HEX));
  assign mac_radix   = (eff_radix == RADIX_AUTO) ? RADIX_DEC : eff_radix;
  assign mac_ok      = dvalid && (dval < DIGIT_W'(mac_radix));

  aip_mac u_mac (
    .acc       (eff_acc),
    .radix     (mac_radix),
    .digit     (dval[MAC_D_W-1:0]),
    .negative  (eff_neg),
    .saturated (eff_sat),
    .acc_nxt   (mac_acc),
    .sat_nxt   (mac_sat)
  );

  // next state
  always_comb begin
    phase_nxt = eff_phase;
    acc_nxt   = eff_acc;
    neg_nxt   = eff_neg;
    radix_nxt = eff_radix;
    pos_nxt   = eff_pos;
    sat_nxt   = eff_sat;
    pfo_nxt   = eff_pfo;
    unique case (eff_phase)
      PH_WS, PH_SIGNED: begin
        if (eff_phase == PH_WS && is_ws) begin
          pos_nxt = pos_inc;
        end else if (eff_phase == PH_WS && is_sign) begin
          neg_nxt   = (ch_r == CH_MINUS);
          phase_nxt = PH_SIGNED;
          pos_nxt   = pos_inc;
        end else if (zero_prefix) begin
          radix_nxt = sel_radix;
          pos_nxt   = pos_inc;
          pfo_nxt   = pos_inc;
          phase_nxt = PH_ZERO;
        end else begin
          radix_nxt = first_radix;
          if (first_ok) begin
            acc_nxt   = VALUE_W'(dval);
            phase_nxt = PH_DIGITS;
            pos_nxt   = pos_inc;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          phase_nxt = PH_XSEEN;
          pos_nxt   = pos_inc;
        end else begin
          radix_nxt = mac_radix;
          if (mac_ok) begin
            acc_nxt   = mac_acc;
            sat_nxt   = mac_sat;
            pos_nxt   = pos_inc;
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_XSEEN: begin
        radix_nxt = RADIX_HEX;
        if (hex_ok) begin
          acc_nxt   = VALUE_W'(dval);
          phase_nxt = PH_DIGITS;
          pos_nxt   = pos_inc;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (mac_ok) begin
          acc_nxt = mac_acc;
          sat_nxt = mac_sat;
          pos_nxt = pos_inc;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // result of the current character
  always_comb begin
    emit    = 1'b0;
    mag     = '0;
    end_pos = '0;
    conv    = 1'b0;
    unique case (eff_phase)
      PH_WS, PH_SIGNED: begin
        if (!(eff_phase == PH_WS && (is_ws || is_sign)) && !zero_prefix && !first_ok) begin
          emit = 1'b1;
        end
      end
      PH_ZERO: begin
        if (!is_x && !mac_ok) begin
          emit    = 1'b1;
          mag     = eff_acc;
          end_pos = eff_pos;
          conv    = 1'b1;
        end
      end
      PH_XSEEN: begin
        // bare 0x: the result stops just after the zero
        if (!hex_ok) begin
          emit    = 1'b1;
          end_pos = eff_pfo;
          conv    = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (!mac_ok) begin
          emit    = 1'b1;
          mag     = eff_acc;
          end_pos = eff_pos;
          conv    = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign end_ext  = 32'(end_pos);
  assign out_free = !out_v_r || out_s.ready;
  assign fire     = in_v_r && (!emit || out_free);

  assign in_s.ready       = !in_v_r || fire;
  assign out_s.valid      = out_v_r;
  assign out_s.value      = value_r;
  assign out_s.end_offset = end_r;
  assign out_s.overflowed = ovf_r;
  assign out_s.converted  = conv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_select_r <= RADIX_AUTO;
    end else if (cfg_we) begin
      radix_select_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_s.ready) begin
      in_v_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.ready && in_s.valid) begin
      ch_r    <= in_s.ch;
      start_r <= in_s.start_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      radix_r <= RADIX_AUTO;
      pos_r   <= '0;
      sat_r   <= 1'b0;
      pfo_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      radix_r <= radix_nxt;
      pos_r   <= pos_nxt;
      sat_r   <= sat_nxt;
      pfo_r   <= pfo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && emit) begin
      out_v_r <= 1'b1;
    end else if (out_s.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      value_r <= eff_neg ? (VALUE_W'(0) - mag) : mag;
      end_r   <= end_ext[OFFSET_W-1:0];
      ovf_r   <= eff_sat;
      conv_r  <= conv;
    end
  end

  // once a string has ended, nothing more comes out until a new start
  a_done_silent : assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !start_r && phase_r == PH_DONE) |-> !emit)
    else $error("result produced after end of string");

  a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit) |=> out_v_r)
    else $error("result transaction lost");

  a_empty_parse : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !conv_r) |-> (value_r == '0 && end_r == '0 && !ovf_r))
    else $error("non-empty result without conversion");

  a_sat_phase : assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (phase_r == PH_DIGITS || phase_r == PH_DONE))
    else $error("saturation outside digit accumulation");

endmodule
